[rtl/ema_pkg.sv]
// ----------------------------------------------------------------------------
// ema_pkg
// Shared types, widths and helpers for the moving average block with warm-up.
// ----------------------------------------------------------------------------
`default_nettype none

package ema_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 8;
    localparam int AVG_W        = 32;
    localparam int DECAY_W      = 16;
    localparam int WARMUP_W     = 8;
    localparam int FRAC_W       = 16;

    // Derived widths
    localparam int SUM_W       = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int MAG_W       = SUM_W - 1;
    localparam int DIV_W       = ((MAG_W + FRAC_W + 1) / 2) * 2;
    localparam int DIV_STEPS   = DIV_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CMP_W       = (WARMUP_W > COUNT_WIDTH) ? WARMUP_W : COUNT_WIDTH;
    localparam int MUL_A_W     = DECAY_W + 2;
    localparam int ACC_W       = MUL_A_W + AVG_W;
    localparam int WIDE_W      = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY  = 2'd0,
        REG_WARMUP = 2'd1
    } t_reg_idx;

    localparam logic [DECAY_W-1:0]     DECAY_RESET  = 16'd62259;
    localparam logic [WARMUP_W-1:0]    WARMUP_RESET = 8'd16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};

    localparam logic signed [WIDE_W-1:0] AVG_MAX_W = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] AVG_MIN_W = -64'sh0000_0000_8000_0000;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                           operation;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    warmed_up;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic mul_old;
        logic mul_new;
        logic finish_warm;
        logic finish_exp;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic exp_mode;
    } t_dp_stat;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [AVG_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [AVG_W-1:0] res;
        if (x > AVG_MAX_W) begin
            res = AVG_MAX_W[AVG_W-1:0];
        end else if (x < AVG_MIN_W) begin
            res = AVG_MIN_W[AVG_W-1:0];
        end else begin
            res = x[AVG_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/ema_dp.sv]
// ----------------------------------------------------------------------------
// ema_dp
// Datapath: configuration registers, running state, a radix-4 restoring
// divider for the warm-up mean and a shared multiplier for the decay update.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_dp
    import ema_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_out_item            o_out_data
);

    logic [DECAY_W-1:0]           r_decay;
    logic [WARMUP_W-1:0]          r_warmup;
    logic signed [AVG_W-1:0]      r_avg;
    logic signed [SUM_W-1:0]      r_sum;
    logic [COUNT_WIDTH-1:0]       r_count;
    logic                         r_exp;

    logic                         r_neg;
    logic [COUNT_WIDTH-1:0]       r_rem;
    logic [DIV_W-1:0]             r_dvd;
    logic signed [AVG_W-1:0]      r_scaled;
    logic signed [ACC_W-1:0]      r_acc;
    t_out_item                    r_out;

    logic signed [SUM_W-1:0]      n_sum;
    logic [COUNT_WIDTH-1:0]       n_count;
    logic                         n_exp;
    logic [SUM_W-1:0]             w_abs;
    logic signed [WIDE_W-1:0]     w_scaled_wide;
    logic [COUNT_WIDTH-1:0]       n_rem;
    logic [DIV_W-1:0]             n_dvd;
    logic signed [MUL_A_W-1:0]    w_ma;
    logic signed [AVG_W-1:0]      w_mb;
    logic signed [ACC_W-1:0]      w_prod;
    logic signed [ACC_W-1:0]      w_acc_shr;
    logic signed [WIDE_W-1:0]     w_acc_wide;
    logic [WIDE_W-1:0]            w_quo_wide;
    logic signed [WIDE_W-1:0]     w_quo_signed;
    logic [DECAY_W:0]             w_comp;

    assign o_stat.exp_mode = r_exp;
    assign o_out_data      = r_out;

    // Warm-up update of sum, count and mode.
    always_comb begin
        n_sum   = r_sum + {{COUNT_WIDTH{i_in_data.sample[SAMPLE_WIDTH-1]}}, i_in_data.sample};
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        n_exp   = (CMP_W'(n_count) >= CMP_W'(r_warmup)) || (n_count == COUNT_MAX);
        w_abs   = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        w_scaled_wide = {{(WIDE_W-SAMPLE_WIDTH-FRAC_W){i_in_data.sample[SAMPLE_WIDTH-1]}},
                         i_in_data.sample, {FRAC_W{1'b0}}};
    end

    // Two restoring division steps per cycle; the divisor is the sample count.
    always_comb begin
        logic [COUNT_WIDTH:0] trial;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_dvd[DIV_W-1]};
            if (trial >= {1'b0, r_count}) begin
                n_rem = COUNT_WIDTH'(trial - {1'b0, r_count});
                n_dvd = {n_dvd[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[COUNT_WIDTH-1:0];
                n_dvd = {n_dvd[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Shared multiplier: decay times old average, then complement times sample.
    always_comb begin
        w_comp = (DECAY_W+1)'(1 << DECAY_W) - {1'b0, r_decay};
        if (i_cmd.mul_new) begin
            w_ma = signed'({1'b0, w_comp});
            w_mb = r_scaled;
        end else begin
            w_ma = signed'({2'b00, r_decay});
            w_mb = r_avg;
        end
        w_prod       = w_ma * w_mb;
        w_acc_shr    = r_acc >>> FRAC_W;
        w_acc_wide   = {{(WIDE_W-ACC_W){w_acc_shr[ACC_W-1]}}, w_acc_shr};
        w_quo_wide   = WIDE_W'(r_dvd);
        w_quo_signed = r_neg ? -signed'(w_quo_wide) : signed'(w_quo_wide);
    end

    // Configuration and running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= DECAY_RESET;
            r_warmup <= WARMUP_RESET;
            r_avg    <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_exp    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DECAY:  r_decay  <= i_cfg_data[DECAY_W-1:0];
                    REG_WARMUP: r_warmup <= i_cfg_data[WARMUP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                if (i_in_data.operation == OP_CLEAR) begin
                    r_avg   <= '0;
                    r_sum   <= '0;
                    r_count <= '0;
                    r_exp   <= 1'b0;
                end else if (!r_exp) begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_exp   <= n_exp;
                end
            end
            if (i_cmd.finish_warm) begin
                r_avg <= sat32(w_quo_signed);
            end
            if (i_cmd.finish_exp) begin
                r_avg <= sat32(w_acc_wide);
            end
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scaled <= sat32(w_scaled_wide);
            r_neg    <= n_sum[SUM_W-1];
            r_rem    <= '0;
            r_dvd    <= DIV_W'({w_abs[MAG_W-1:0], {FRAC_W{1'b0}}});
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
        if (i_cmd.mul_old) begin
            r_acc <= w_prod;
        end
        if (i_cmd.mul_new) begin
            r_acc <= r_acc + w_prod;
        end
        if (i_cmd.out_load) begin
            r_out.average   <= r_avg;
            r_out.warmed_up <= r_exp;
        end
    end

endmodule

`default_nettype wire

[rtl/ema_ctrl.sv]
// ----------------------------------------------------------------------------
// ema_ctrl
// Controller: sequences the divider or the multiply steps for one item and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_ctrl
    import ema_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_op_clear,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV     = 6'b000010,
        S_MUL_OLD = 6'b000100,
        S_MUL_NEW = 6'b001000,
        S_FINISH  = 6'b010000,
        S_WRITE   = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_warm_path, n_warm_path;
    logic                   r_out_valid, n_out_valid;
    logic                   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_warm_path = r_warm_path;
        o_cmd       = '0;
        o_cmd.start = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    if (i_op_clear) begin
                        n_state = S_WRITE;
                    end else if (i_stat.exp_mode) begin
                        n_warm_path = 1'b0;
                        n_state     = S_MUL_OLD;
                    end else begin
                        n_warm_path = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_MUL_OLD: begin
                o_cmd.mul_old = 1'b1;
                n_state       = S_MUL_NEW;
            end
            S_MUL_NEW: begin
                o_cmd.mul_new = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish_warm = r_warm_path;
                o_cmd.finish_exp  = !r_warm_path;
                n_state           = S_WRITE;
            end
            S_WRITE: begin
                // The output register is free once its transaction completes.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_warm_path <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_warm_path <= n_warm_path;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/exp_moving_average_warmup_top.sv]
// ----------------------------------------------------------------------------
// exp_moving_average_warmup_top
// Moving average of signed samples in Q15.16, plain mean during warm-up and
// exponential decay afterwards.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions on i_in_valid / o_in_ready carry an operation and a
// sample; every one returns one result (average, warmed_up) on
// o_out_valid / i_out_ready. Configuration writes on i_cfg_valid /
// o_cfg_ready (always ready) set decay (index 0) and warmup_samples
// (index 1); other indices are ignored. Write them only while idle.
// One item is worked on at a time. A warm-up sample, once accepted, runs
// the two-bit-per-cycle divider forming sum * 65536 / count, then a step
// that applies the sign and saturates, then a step that loads the output
// register; the next item is taken once the controller is back in idle.
// An exponential-mode sample runs two multiply steps that share one
// 18 x 32 multiplier, then the sign-and-saturate and load steps.
// A clear goes straight to the load step.
// The output register holds a result until it is taken; the next item may
// be accepted and processed meanwhile, and waits only at the load step.
// Reset (synchronous, active low) restores register defaults and clears the
// average, sum, count and mode.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_moving_average_warmup_top
    import ema_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out_item            o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ema_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op_clear  (i_in_data.operation == OP_CLEAR),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ema_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
